// ===== src/tlp_pkg.sv =====
// Shared constants, codes and types of the task latency profiler.
`timescale 1ns / 1ps

package tlp_pkg;

   localparam int MAX_TASKS   = 16;
   localparam int ID_W        = 4;
   localparam int CNT_W       = 5;
   localparam int DATA_W      = 32;
   localparam int QUEUE_DEPTH = 2;

   // operation codes on the request channel
   localparam logic [2:0] OP_RELEASE  = 3'd0;
   localparam logic [2:0] OP_START    = 3'd1;
   localparam logic [2:0] OP_COMPLETE = 3'd2;
   localparam logic [2:0] OP_QUERY    = 3'd3;
   localparam logic [2:0] OP_CLEAR    = 3'd4;

   // register index, taken from paddr[2]
   localparam logic REG_ENABLE = 1'b0;
   localparam logic REG_TASKS  = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_TASK = 1'b1;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_RELEASE,
      CMD_START,
      CMD_COMPLETE,
      CMD_QUERY,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      logic             counting_enabled;
      logic [CNT_W-1:0] active_tasks;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [ID_W-1:0]   task_id;
      logic              coalesced;
      logic [DATA_W-1:0] now_cycle;
      logic              query_bad;
      logic [CNT_W-1:0]  clear_count;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   typedef struct packed {
      logic [DATA_W-1:0] num_released;
      logic [DATA_W-1:0] num_completed;
      logic [DATA_W-1:0] num_coalesced;
      logic [DATA_W-1:0] max_latency;
      logic [DATA_W-1:0] max_duration;
      logic [DATA_W-1:0] release_stamp;
      logic [DATA_W-1:0] start_stamp;
   } rec_type;

endpackage

// ===== src/tlp_if.sv =====
// Request and response channel interfaces of the task latency profiler.
`timescale 1ns / 1ps

interface tlp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [3:0]  task_id;
   logic        coalesced;
   logic [31:0] now_cycle;

   modport source (output valid, operation, task_id, coalesced, now_cycle, input ready);
   modport sink (input valid, operation, task_id, coalesced, now_cycle, output ready);
endinterface

interface tlp_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] release_total;
   logic [31:0] completion_total;
   logic [31:0] coalesced_total;
   logic [31:0] pending_total;
   logic [31:0] worst_latency;
   logic [31:0] worst_duration;

   modport source (output valid, status, release_total, completion_total, coalesced_total,
                   pending_total, worst_latency, worst_duration, input ready);
   modport sink (input valid, status, release_total, completion_total, coalesced_total,
                 pending_total, worst_latency, worst_duration, output ready);
endinterface

// ===== src/tlp_front.sv =====
// Front end: accepts request words and turns them into back-end commands.
`timescale 1ns / 1ps

module tlp_front import tlp_pkg::*; (
   tlp_req_if.sink  req_chan,
   input  cfg_type  cfg,
   input  logic     q_full,
   output logic     q_push,
   output cmd_type  q_cmd
);

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   always_comb begin
      q_cmd.task_id   = req_chan.task_id;
      q_cmd.coalesced = req_chan.coalesced;
      q_cmd.now_cycle = req_chan.now_cycle;
      q_cmd.query_bad = CNT_W'(req_chan.task_id) >= cfg.active_tasks;
      // clamp the clear walk to the table size
      if (cfg.active_tasks > CNT_W'(MAX_TASKS)) begin
         q_cmd.clear_count = CNT_W'(MAX_TASKS);
      end else begin
         q_cmd.clear_count = cfg.active_tasks;
      end
      unique case (req_chan.operation)
         OP_RELEASE:  q_cmd.kind = cfg.counting_enabled ? CMD_RELEASE : CMD_NOP;
         OP_START:    q_cmd.kind = cfg.counting_enabled ? CMD_START : CMD_NOP;
         OP_COMPLETE: q_cmd.kind = cfg.counting_enabled ? CMD_COMPLETE : CMD_NOP;
         OP_QUERY:    q_cmd.kind = CMD_QUERY;
         OP_CLEAR:    q_cmd.kind = CMD_CLEAR;
         default:     q_cmd.kind = CMD_NOP;
      endcase
   end

endmodule

// ===== src/tlp_queue.sv =====
// Command queue between the front end and the back end.
`timescale 1ns / 1ps

module tlp_queue import tlp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cmd_type    push_cmd,
   output logic       full,
   input  logic       pop,
   output q_head_type head
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               do_push;
   logic               do_pop;

   assign full       = count_ff == COUNT_W'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.cmd   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            entries_ff[wr_ptr_ff] <= push_cmd;
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== src/tlp_back.sv =====
// Back end: task record table, read-modify-write sequencer and response register.
`timescale 1ns / 1ps

module tlp_back import tlp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_head_type head,
   output logic       q_pop,
   tlp_rsp_if.source  rsp_chan
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_CLEAR
   } state_type;

   state_type              state_ff;
   cmd_type                cmd_ff;
   rec_type                rec_ff;
   logic                   pend_ff;
   logic                   run_ff;
   rec_type                table_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0]   pending_ff;
   logic [MAX_TASKS-1:0]   running_ff;
   logic [CNT_W-1:0]       idx_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_status_ff;
   logic [DATA_W-1:0]      rsp_release_ff;
   logic [DATA_W-1:0]      rsp_completion_ff;
   logic [DATA_W-1:0]      rsp_coalesced_ff;
   logic [DATA_W-1:0]      rsp_pending_ff;
   logic [DATA_W-1:0]      rsp_latency_ff;
   logic [DATA_W-1:0]      rsp_duration_ff;

   rec_type                rec_in;
   rec_type                clear_rec;
   logic                   pend_in;
   logic                   run_in;
   logic                   rsp_status_in;
   logic [DATA_W-1:0]      rsp_release_in;
   logic [DATA_W-1:0]      rsp_completion_in;
   logic [DATA_W-1:0]      rsp_coalesced_in;
   logic [DATA_W-1:0]      rsp_pending_in;
   logic [DATA_W-1:0]      rsp_latency_in;
   logic [DATA_W-1:0]      rsp_duration_in;
   logic [DATA_W-1:0]      latency;
   logic [DATA_W-1:0]      duration;
   logic [DATA_W-1:0]      rel_minus_com;
   logic [CNT_W-1:0]       idx_next;
   logic                   slot_free;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop     = (state_ff == S_IDLE) && head.valid && slot_free;
   assign idx_next  = idx_ff + 1'b1;
   assign latency   = cmd_ff.now_cycle - rec_ff.release_stamp;
   assign duration  = cmd_ff.now_cycle - rec_ff.start_stamp;
   assign rel_minus_com = rec_ff.num_released - rec_ff.num_completed;

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.release_total    = rsp_release_ff;
   assign rsp_chan.completion_total = rsp_completion_ff;
   assign rsp_chan.coalesced_total  = rsp_coalesced_ff;
   assign rsp_chan.pending_total    = rsp_pending_ff;
   assign rsp_chan.worst_latency    = rsp_latency_ff;
   assign rsp_chan.worst_duration   = rsp_duration_ff;

   // stamps of idle records are dead, so a clear may restamp every record it walks
   always_comb begin
      clear_rec               = '0;
      clear_rec.release_stamp = cmd_ff.now_cycle;
      clear_rec.start_stamp   = cmd_ff.now_cycle;
   end

   always_comb begin
      rec_in            = rec_ff;
      pend_in           = pend_ff;
      run_in            = run_ff;
      rsp_status_in     = STATUS_OK;
      rsp_release_in    = '0;
      rsp_completion_in = '0;
      rsp_coalesced_in  = '0;
      rsp_pending_in    = '0;
      rsp_latency_in    = '0;
      rsp_duration_in   = '0;
      unique case (cmd_ff.kind)
         CMD_RELEASE: begin
            rec_in.num_released = rec_ff.num_released + 1'b1;
            if (cmd_ff.coalesced) begin
               rec_in.num_coalesced = rec_ff.num_coalesced + 1'b1;
            end
            if (!pend_ff) begin
               rec_in.release_stamp = cmd_ff.now_cycle;
               pend_in = 1'b1;
            end
         end
         CMD_START: begin
            if (pend_ff && !run_ff) begin
               if (latency > rec_ff.max_latency) begin
                  rec_in.max_latency = latency;
               end
               rec_in.start_stamp = cmd_ff.now_cycle;
               pend_in = 1'b0;
               run_in  = 1'b1;
            end
         end
         CMD_COMPLETE: begin
            if (run_ff) begin
               if (duration > rec_ff.max_duration) begin
                  rec_in.max_duration = duration;
               end
               rec_in.num_completed = rec_ff.num_completed + 1'b1;
               run_in = 1'b0;
            end
         end
         CMD_QUERY: begin
            if (cmd_ff.query_bad) begin
               rsp_status_in = STATUS_BAD_TASK;
            end else begin
               rsp_release_in    = rec_ff.num_released;
               rsp_completion_in = rec_ff.num_completed;
               rsp_coalesced_in  = rec_ff.num_coalesced;
               rsp_latency_in    = rec_ff.max_latency;
               rsp_duration_in   = rec_ff.max_duration;
               // report zero when the counts disagree
               if (rec_ff.num_completed > rec_ff.num_released ||
                   rec_ff.num_coalesced > rel_minus_com) begin
                  rsp_pending_in = '0;
               end else begin
                  rsp_pending_in = rel_minus_com - rec_ff.num_coalesced;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         pending_ff   <= '0;
         running_ff   <= '0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            table_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  cmd_ff   <= head.cmd;
                  rec_ff   <= table_ff[head.cmd.task_id];
                  pend_ff  <= pending_ff[head.cmd.task_id];
                  run_ff   <= running_ff[head.cmd.task_id];
                  idx_ff   <= '0;
                  state_ff <= (head.cmd.kind == CMD_CLEAR) ? S_CLEAR : S_EXEC;
               end
            end
            S_EXEC: begin
               table_ff[cmd_ff.task_id]   <= rec_in;
               pending_ff[cmd_ff.task_id] <= pend_in;
               running_ff[cmd_ff.task_id] <= run_in;
               rsp_valid_ff      <= 1'b1;
               rsp_status_ff     <= rsp_status_in;
               rsp_release_ff    <= rsp_release_in;
               rsp_completion_ff <= rsp_completion_in;
               rsp_coalesced_ff  <= rsp_coalesced_in;
               rsp_pending_ff    <= rsp_pending_in;
               rsp_latency_ff    <= rsp_latency_in;
               rsp_duration_ff   <= rsp_duration_in;
               state_ff          <= S_IDLE;
            end
            S_CLEAR: begin
               if (idx_ff < cmd_ff.clear_count) begin
                  table_ff[idx_ff[ID_W-1:0]] <= clear_rec;
               end
               idx_ff <= idx_next;
               if (idx_next >= cmd_ff.clear_count) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_status_ff     <= STATUS_OK;
                  rsp_release_ff    <= '0;
                  rsp_completion_ff <= '0;
                  rsp_coalesced_ff  <= '0;
                  rsp_pending_ff    <= '0;
                  rsp_latency_ff    <= '0;
                  rsp_duration_ff   <= '0;
                  state_ff          <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // a result word appears only at the end of an update or a clear walk
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EXEC || $past(state_ff) == S_CLEAR))
      else $error("response raised outside update or clear");

   // work starts only once the response register has been emptied
   a_slot_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC || state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("response register busy while working");

   // clear walk stays inside the table
   a_clear_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> idx_ff < CNT_W'(MAX_TASKS))
      else $error("clear index beyond table");
`endif

endmodule

// ===== src/task_latency_profiler.sv =====
// Top level of the task latency profiler: register port, front end, queue, back end.
`timescale 1ns / 1ps

// Each request word is classified by the front end and parked in a two-word command
// queue, so req_chan.ready stays high while the queue has room even if a response waits.
// The back end takes one command at a time: release, start, complete, query and unused
// codes read the table into a register, then update it and write the response register,
// and clear walks N = min(active_tasks, 16) records, one record per cycle, responding at
// the walk's end. A response is held in an output register until rsp_chan.ready.
// Registers: 0x0 counting_enabled (bit 0), 0x4 active_tasks (bits 4:0); write them idle.

module task_latency_profiler import tlp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tlp_req_if.sink     req_chan,
   tlp_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type    cfg_ff;
   logic       csr_write;
   logic       q_push;
   logic       q_full;
   logic       q_pop;
   cmd_type    q_cmd;
   q_head_type q_head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.counting_enabled <= 1'b0;
         cfg_ff.active_tasks     <= CNT_W'(MAX_TASKS);
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_ENABLE: cfg_ff.counting_enabled <= pwdata[0];
            REG_TASKS:  cfg_ff.active_tasks     <= pwdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_ENABLE: prdata = {31'd0, cfg_ff.counting_enabled};
         REG_TASKS:  prdata = {{(32 - CNT_W){1'b0}}, cfg_ff.active_tasks};
         default:    prdata = '0;
      endcase
   end

   tlp_front u_front (
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_cmd)
   );

   tlp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head)
   );

   tlp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
